### rtl/vlss_pkg.sv
// Shared types and constants for the value list with search and sort.
package vlss_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int TYPE_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;

   // request codes
   typedef enum logic [TYPE_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_POP       = 3'd1,
      OP_SEARCH    = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_ALL   = 3'd4,
      OP_SORT      = 3'd5,
      OP_CLEAR     = 3'd6
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE_OK = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_RUN,
      FSM_DONE
   } fsm_type;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_IN,   // take left neighbor (head takes the key)
      CELL_SHIFT_OUT,  // take right neighbor where take is set
      CELL_SORT        // odd-even compare-exchange
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        parity;
   } cell_ctl_type;

endpackage

### rtl/vlss_cell.sv
// One list slot: holds an entry, compares it with the key, trades with neighbors.
module vlss_cell import vlss_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic                      take,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] key,
   input  logic signed [VALUE_W-1:0] left_val,
   input  logic signed [VALUE_W-1:0] right_val,
   output logic signed [VALUE_W-1:0] val,
   output logic                      match
);

   localparam logic [CNT_W-1:0] IDX_C   = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NEXT_C  = CNT_W'(IDX + 1);
   localparam logic             IS_ODD  = ((IDX % 2) == 1);
   localparam logic             HAS_LFT = (IDX > 0);

   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      valid, right_valid, is_left;

   assign valid       = (IDX_C < count);
   assign right_valid = (NEXT_C < count);
   assign is_left     = (IS_ODD == ctl.parity);
   assign match       = valid && (val_ff == key);
   assign val         = val_ff;

   always_comb begin
      val_in = val_ff;
      case (ctl.op)
         CELL_SHIFT_IN: val_in = left_val;
         CELL_SHIFT_OUT: begin
            if (take) val_in = right_val;
         end
         CELL_SORT: begin
            // left of pair keeps the min, right of pair keeps the max
            if (is_left) begin
               if (right_valid && (right_val < val_ff)) val_in = right_val;
            end else if (HAS_LFT && valid) begin
               if (left_val > val_ff) val_in = left_val;
            end
         end
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### rtl/value_list_with_search_and_sort_top.sv
// Top level of the value list: request buffer, control FSM and the row of slot cells.
//
//  channel | direction | ports                                      | handshake
//  --------+-----------+--------------------------------------------+----------------------
//  req     | in        | req_type[2:0], req_value[31:0] signed      | req_valid / req_ready
//  rsp     | out       | rsp_status[1:0], rsp_found, rsp_count[4:0],| rsp_valid / rsp_ready
//          |           | rsp_head_value[31:0] signed                |
//
// Request flow: every request goes from IDLE to DONE, where the response register is loaded;
// delete all with a match passes through RUN, dropping one match per cycle until none is left;
// sort of two or more entries passes through RUN, one odd-even compare-exchange pass per cycle
// across the cell row, until the pass counter reaches the entry count less one; other sorts skip RUN.
// One request is worked on at a time; a second one is buffered while a response waits.
// Reset clears the entry count, FSM and valid flags; slot contents are not reset and
// slots at or above the count are never observed.
// A stalled response keeps the FSM from starting; the buffered request waits for the output.
module value_list_with_search_and_sort_top import vlss_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [TYPE_W-1:0]          req_type,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic signed [VALUE_W-1:0]  rsp_head_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LVLS  = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   // FSM and bookkeeping
   fsm_type                   state_ff, state_in;
   logic                      pend_ff, pend_in;
   logic [TYPE_W-1:0]         op_ff, op_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          pass_ff, pass_in;
   status_type                status_ff, status_in;
   logic                      found_ff, found_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_head_ff, rsp_head_in;

   // cell row
   cell_ctl_type              ctl;
   logic [CAPACITY-1:0]       take_vec;
   logic [CAPACITY-1:0]       match_vec;
   logic [CAPACITY-1:0]       pre_vec;
   logic                      any_match;
   logic signed [VALUE_W-1:0] vals [CAPACITY];

   logic req_fire, out_free, start;

   assign req_ready = !pend_ff || (state_ff == FSM_DONE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == FSM_IDLE) && pend_ff && out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_head_value = rsp_head_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] lv, rv;
      if (g == 0) begin : g_head
         assign lv = key_ff;
      end else begin : g_mid_l
         assign lv = vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign rv = '0;
      end else begin : g_mid_r
         assign rv = vals[g+1];
      end
      vlss_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .take      (take_vec[g]),
         .count     (count_ff),
         .key       (key_ff),
         .left_val  (lv),
         .right_val (rv),
         .val       (vals[g]),
         .match     (match_vec[g])
      );
   end

   // inclusive prefix OR of matches (log-depth): marks the first match and all after it
   always_comb begin
      logic [CAPACITY-1:0] tmp;
      pre_vec = match_vec;
      for (int lv = 0; lv < LVLS; lv++) begin
         tmp = pre_vec;
         for (int i = 0; i < CAPACITY; i++) begin
            if (i >= (1 << lv)) pre_vec[i] = tmp[i] | tmp[i - (1 << lv)];
         end
      end
   end
   assign any_match = pre_vec[CAPACITY-1];

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      pass_in       = pass_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_head_in   = rsp_head_ff;
      ctl.op        = CELL_HOLD;
      ctl.parity    = 1'b0;
      take_vec      = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               status_in = ST_DONE_OK;
               found_in  = 1'b0;
               state_in  = FSM_DONE;
               case (op_ff)
                  OP_INSERT: begin
                     found_in = any_match;
                     if (count_ff == CAP_C) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.op   = CELL_SHIFT_IN;
                        count_in = count_ff + ONE_C;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ctl.op   = CELL_SHIFT_OUT;
                        take_vec = '1;
                        count_in = count_ff - ONE_C;
                     end
                  end
                  OP_SEARCH, OP_DEL_FIRST, OP_DEL_ALL: begin
                     found_in = any_match;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (!any_match) begin
                        status_in = ST_ABSENT;
                     end else if (op_ff != OP_SEARCH) begin
                        ctl.op   = CELL_SHIFT_OUT;
                        take_vec = pre_vec;
                        count_in = count_ff - ONE_C;
                        if (op_ff == OP_DEL_ALL) state_in = FSM_RUN;
                     end
                  end
                  OP_SORT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (count_ff != ONE_C) begin
                        pass_in  = '0;
                        state_in = FSM_RUN;
                     end
                  end
                  OP_CLEAR: begin
                     if (count_ff == '0) status_in = ST_EMPTY;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         FSM_RUN: begin
            if (op_ff == OP_SORT) begin
               ctl.op     = CELL_SORT;
               ctl.parity = pass_ff[0];
               pass_in    = pass_ff + ONE_C;
               if (pass_ff == count_ff - ONE_C) state_in = FSM_DONE;
            end else if (any_match) begin
               // delete all: drop the first remaining match each cycle
               ctl.op   = CELL_SHIFT_OUT;
               take_vec = pre_vec;
               count_in = count_ff - ONE_C;
            end else begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_found_in  = found_ff;
            rsp_count_in  = COUNT_W'(count_ff);
            rsp_head_in   = (count_ff != '0) ? vals[0] : '0;
            pend_in       = 1'b0;
            state_in      = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase

      if (req_fire) begin
         pend_in = 1'b1;
         op_in   = req_type;
         key_in  = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pass_ff       <= pass_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_head_ff   <= rsp_head_in;
   end

endmodule

### dv/value_list_with_search_and_sort_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the value list: directed table, then random requests.
module value_list_with_search_and_sort_top_test import vlss_pkg::*;;

   // ------------------------------------------------------------------
   // Constants
   // ------------------------------------------------------------------
   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 910;
   localparam int HOLD_AT      = 400;   // response count where the receiver backs off
   localparam int HOLD_CYCLES  = 90;
   localparam int PAUSE_AT     = 650;   // random request where the sender drains
   localparam int MAX_PRINTS   = 30;

   // code seven is not decoded; the block must leave the list alone
   localparam logic [TYPE_W-1:0] OP_UNUSED = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   // one response as the list would report it
   typedef struct packed {
      status_type                status;
      logic                      found;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] head;
   } list_result_type;

   // a row of the directed table; reps/step expand one row into a run of requests
   typedef struct packed {
      logic [TYPE_W-1:0]         op;
      logic signed [VALUE_W-1:0] val;
      logic [4:0]                reps;
      logic signed [7:0]         step;
      logic                      has_want;
      list_result_type           want;
   } script_row_type;

   localparam list_result_type NONE      = '0;
   localparam list_result_type EMPTY_OUT = '{ST_EMPTY, 1'b0, 5'd0, 32'sd0};
   localparam list_result_type CLEARED   = '{ST_DONE_OK, 1'b0, 5'd0, 32'sd0};

   // ------------------------------------------------------------------
   // Directed table. Rows with has_want set carry an expectation that is
   // obvious from the list contents; the rest go through the predictor.
   // ------------------------------------------------------------------
   localparam int SCRIPT_LEN = 26;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // every request but insert against the empty list
      '{OP_POP,       32'sd0,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_SEARCH,    32'sd5,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_DEL_FIRST, 32'sd5,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_DEL_ALL,   32'sd5,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_SORT,      32'sd0,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_CLEAR,     32'sd0,     5'd1,  8'sd0, 1'b1, EMPTY_OUT},
      '{OP_UNUSED,    32'sd0,     5'd1,  8'sd0, 1'b1, CLEARED},
      // value extremes, single-entry sort, duplicate insert, absent search
      '{OP_INSERT,    VAL_MAX,    5'd1,  8'sd0, 1'b1, '{ST_DONE_OK, 1'b0, 5'd1, VAL_MAX}},
      '{OP_SORT,      32'sd0,     5'd1,  8'sd0, 1'b1, '{ST_DONE_OK, 1'b0, 5'd1, VAL_MAX}},
      '{OP_INSERT,    VAL_MIN,    5'd1,  8'sd0, 1'b1, '{ST_DONE_OK, 1'b0, 5'd2, VAL_MIN}},
      '{OP_INSERT,    VAL_MIN,    5'd1,  8'sd0, 1'b1, '{ST_DONE_OK, 1'b1, 5'd3, VAL_MIN}},
      '{OP_SEARCH,    32'sd0,     5'd1,  8'sd0, 1'b1, '{ST_ABSENT, 1'b0, 5'd3, VAL_MIN}},
      '{OP_SEARCH,    VAL_MAX,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_INSERT,    -32'sd1,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_SORT,      32'sd0,     5'd1,  8'sd0, 1'b0, NONE},
      '{OP_DEL_FIRST, VAL_MIN,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_INSERT,    VAL_MIN,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_DEL_ALL,   VAL_MIN,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_DEL_FIRST, 32'sd12345, 5'd1,  8'sd0, 1'b0, NONE},
      '{OP_UNUSED,    -32'sd1,    5'd1,  8'sd0, 1'b0, NONE},
      '{OP_CLEAR,     32'sd0,     5'd1,  8'sd0, 1'b1, CLEARED},
      // fill to capacity in descending order, overflow, then a full reversal
      '{OP_INSERT,    -32'sd8,    5'd16, 8'sd1, 1'b0, NONE},
      '{OP_INSERT,    32'sd42,    5'd1,  8'sd0, 1'b1, '{ST_FULL, 1'b0, 5'd16, 32'sd7}},
      '{OP_SORT,      32'sd0,     5'd1,  8'sd0, 1'b1, '{ST_DONE_OK, 1'b0, 5'd16, -32'sd8}},
      '{OP_DEL_ALL,   32'sd0,     5'd1,  8'sd0, 1'b0, NONE},
      '{OP_CLEAR,     32'sd0,     5'd1,  8'sd0, 1'b1, CLEARED}
   };

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic [TYPE_W-1:0]         req_type  = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_ready = 1'b0;
   logic                      req_ready;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_found;
   logic [COUNT_W-1:0]        rsp_count;
   logic signed [VALUE_W-1:0] rsp_head_value;

   value_list_with_search_and_sort_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_count      (rsp_count),
      .rsp_head_value (rsp_head_value)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Scoreboard state
   // ------------------------------------------------------------------
   logic signed [VALUE_W-1:0] list_q[$];       // predicted list, head at index 0
   list_result_type           pending_rsp_q[$]; // responses still owed by the block
   logic signed [VALUE_W-1:0] value_pool[8];

   int unsigned fail_count = 0;
   int unsigned n_sent     = 0;
   int unsigned rsp_seen   = 0;
   int unsigned n_full     = 0;
   int unsigned n_empty    = 0;
   int unsigned n_long_sort = 0;
   int unsigned n_at_cap   = 0;

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("ERROR @%0t rsp #%0d: %s", $time, rsp_seen, msg);
   endtask

   // Apply one request to the predicted list and return what the block should report.
   function automatic list_result_type apply_request(input logic [TYPE_W-1:0] op,
                                                     input logic signed [VALUE_W-1:0] val);
      list_result_type           r;
      logic                      hit;
      logic signed [VALUE_W-1:0] key;
      int                        k;
      int                        j;
      r        = '0;
      r.status = ST_DONE_OK;
      hit      = 1'b0;
      foreach (list_q[i])
         if (list_q[i] == val) hit = 1'b1;
      case (op)
         OP_INSERT: begin
            r.found = hit;
            if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
            else list_q.push_front(val);
         end
         OP_POP: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            else void'(list_q.pop_front());
         end
         OP_SEARCH, OP_DEL_FIRST, OP_DEL_ALL: begin
            if (list_q.size() == 0) begin
               r.status = ST_EMPTY;
            end else if (!hit) begin
               r.status = ST_ABSENT;
            end else begin
               r.found = 1'b1;
               if (op == OP_DEL_FIRST) begin
                  for (k = 0; k < list_q.size(); k++)
                     if (list_q[k] == val) begin
                        list_q.delete(k);
                        break;
                     end
               end else if (op == OP_DEL_ALL) begin
                  for (k = list_q.size() - 1; k >= 0; k--)
                     if (list_q[k] == val) list_q.delete(k);
               end
            end
         end
         OP_SORT: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            for (k = 1; k < list_q.size(); k++) begin
               key = list_q[k];
               j   = k;
               while (j > 0 && key < list_q[j-1]) begin
                  list_q[j] = list_q[j-1];
                  j--;
               end
               list_q[j] = key;
            end
         end
         OP_CLEAR: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            list_q.delete();
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_q.size());
      r.head  = (list_q.size() != 0) ? list_q[0] : '0;
      return r;
   endfunction

   // Random request mix. Phase 0 leans on inserts so the list fills up,
   // phase 2 leans on removals so it drains and hits the empty cases.
   function automatic logic [TYPE_W-1:0] pick_op(input int phase);
      int r;
      int ins_pct;
      ins_pct = (phase == 0) ? 70 : (phase == 1) ? 35 : 15;
      if ($urandom_range(0, 99) < ins_pct) return OP_INSERT;
      r = $urandom_range(0, 99);
      if (r < 22) return OP_POP;
      if (r < 42) return OP_SEARCH;
      if (r < 57) return OP_DEL_FIRST;
      if (r < 70) return OP_DEL_ALL;
      if (r < 92) return OP_SORT;
      if (r < 97) return (phase == 0) ? OP_SORT : OP_CLEAR;
      return OP_UNUSED;
   endfunction

   // Mostly a small pool so searches hit and duplicates pile up.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return value_pool[$urandom_range(0, 7)];
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // Sender: called at a falling edge, returns at the falling edge after acceptance.
   task automatic send_request(input logic [TYPE_W-1:0]         op,
                               input logic signed [VALUE_W-1:0] val,
                               input int unsigned               gap,
                               input logic                      has_want,
                               input list_result_type           want);
      list_result_type pred;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      if (op == OP_SORT && list_q.size() > 1) n_long_sort++;
      pred = apply_request(op, val);
      if (pred.status == ST_FULL) n_full++;
      if (pred.status == ST_EMPTY) n_empty++;
      if (pred.count == LIST_DEPTH) n_at_cap++;
      pending_rsp_q.push_back(has_want ? want : pred);
      n_sent++;
      @(negedge clock);
   endtask

   // sender gaps: bursts with no idling every fourth block of 100
   function automatic int unsigned sender_gap(input int n);
      return ((n / 100) % 4 == 1) ? 0 : $urandom_range(0, 9);
   endfunction

   // ------------------------------------------------------------------
   // Response checker: compare each accepted response with the oldest
   // expectation, field by field
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status)
               flag_error($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_found !== want.found)
               flag_error($sformatf("found %0b, want %0b", rsp_found, want.found));
            if (rsp_count !== want.count)
               flag_error($sformatf("count %0d, want %0d", rsp_count, want.count));
            if (rsp_head_value !== want.head)
               flag_error($sformatf("head %0d, want %0d", rsp_head_value, want.head));
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall per response, a stretch of always-ready, and
   // one long hold-off so the block backs up and drops req_ready
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ((rsp_seen / 80) % 4 == 2) ? 0 : $urandom_range(0, 9);
         if (rsp_seen == HOLD_AT) gap = HOLD_CYCLES;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stim
      int                        r;
      int                        k;
      logic [TYPE_W-1:0]         op;
      logic signed [VALUE_W-1:0] val;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (r = 0; r < SCRIPT_LEN; r++)
         for (k = 0; k < SCRIPT[r].reps; k++) begin
            val = SCRIPT[r].val + k * SCRIPT[r].step;
            send_request(SCRIPT[r].op, val, sender_gap(n_sent),
                         SCRIPT[r].has_want, SCRIPT[r].want);
         end

      // random requests
      for (r = 0; r < RANDOM_ITEMS; r++) begin
         if (r % 128 == 0)
            foreach (value_pool[i]) value_pool[i] = $urandom;
         if (r == PAUSE_AT) begin
            // let the block drain completely before going on
            req_valid <= 1'b0;
            while (pending_rsp_q.size() != 0) @(negedge clock);
            @(negedge clock);
         end
         op  = pick_op((r / 60) % 3);
         val = pick_value();
         send_request(op, val, sender_gap(n_sent), 1'b0, NONE);
      end
      req_valid <= 1'b0;

      // drain, then idle a while to catch any stray response
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests, checked %0d responses; %0d inserts hit a full list,",
               n_sent, rsp_seen, n_full);
      $display("%0d requests found the list empty, %0d sorts had 2+ entries, %0d at capacity",
               n_empty, n_long_sort, n_at_cap);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog: well beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d responses outstanding", pending_rsp_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule
